FILE: sv/sfpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpid_pkg - shared types and microcode for the SEA force PID controller
// Control word layout, operand and operation codes, spring constants and the
// program ROM of the sequencer.
// ----------------------------------------------------------------------------
package sfpid_pkg;

	localparam int PC_W  = 4;
	localparam int IDX_W = 3;

	// spring coefficients, Q0.32
	localparam logic signed [31:0] SPRING_K1 = 32'sd22419729;
	localparam logic signed [31:0] SPRING_K2 = 32'sd117682;

	localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
	localparam logic [PC_W-1:0] PC_OUT  = 4'd13;

	typedef enum logic [IDX_W-1:0] {
		REG_FF_GAIN  = 3'd0,
		REG_KP_GAIN  = 3'd1,
		REG_KI_GAIN  = 3'd2,
		REG_KD_GAIN  = 3'd3,
		REG_INT_LIM  = 3'd4,
		REG_TRQ_LIM  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		A_D, A_SQH, A_SQL, A_FF, A_KP, A_KI, A_KD
	} a_sel_t;

	typedef enum logic [2:0] {
		B_K1, B_D, B_K2, B_REF, B_ERR, B_INT, B_DERR
	} b_sel_t;

	typedef enum logic [3:0] {
		OP_NONE,    // no register update
		OP_LIN,     // linear spring term from product
		OP_SQ,      // squared deflection, scaled
		OP_QH,      // upper partial of quadratic term
		OP_QL,      // merge lower partial
		OP_MEAS,    // measured torque
		OP_ERR,     // torque error
		OP_INT,     // integrator, error difference, first sum term
		OP_SUMADD,  // add next gain term
		OP_OUT      // clamp and load result
	} op_t;

	typedef enum logic [1:0] {
		C_ALWAYS,   // jump unconditionally
		C_IN_XFER,  // jump once an input transfer happens
		C_OUT_FREE  // jump once the result register can be loaded
	} cond_t;

	typedef struct packed {
		a_sel_t          a;
		b_sel_t          b;
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{a: A_D, b: B_D, op: OP_NONE, cond: C_ALWAYS, target: PC_WAIT};
		case (pc)
			4'd0:  w = '{A_D,   B_D,    OP_NONE,   C_IN_XFER,  4'd1};
			4'd1:  w = '{A_D,   B_K1,   OP_NONE,   C_ALWAYS,   4'd2};
			4'd2:  w = '{A_D,   B_D,    OP_LIN,    C_ALWAYS,   4'd3};
			4'd3:  w = '{A_D,   B_D,    OP_SQ,     C_ALWAYS,   4'd4};
			4'd4:  w = '{A_SQH, B_K2,   OP_NONE,   C_ALWAYS,   4'd5};
			4'd5:  w = '{A_SQL, B_K2,   OP_QH,     C_ALWAYS,   4'd6};
			4'd6:  w = '{A_D,   B_D,    OP_QL,     C_ALWAYS,   4'd7};
			4'd7:  w = '{A_D,   B_D,    OP_MEAS,   C_ALWAYS,   4'd8};
			4'd8:  w = '{A_FF,  B_REF,  OP_ERR,    C_ALWAYS,   4'd9};
			4'd9:  w = '{A_KP,  B_ERR,  OP_INT,    C_ALWAYS,   4'd10};
			4'd10: w = '{A_KI,  B_INT,  OP_SUMADD, C_ALWAYS,   4'd11};
			4'd11: w = '{A_KD,  B_DERR, OP_SUMADD, C_ALWAYS,   4'd12};
			4'd12: w = '{A_D,   B_D,    OP_SUMADD, C_ALWAYS,   4'd13};
			4'd13: w = '{A_D,   B_D,    OP_OUT,    C_OUT_FREE, PC_WAIT};
			default: w = '{A_D, B_D,    OP_NONE,   C_ALWAYS,   PC_WAIT};
		endcase
		return w;
	endfunction

	// saturate a 34-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [33:0] vmax;
		logic signed [33:0] vmin;
		vmax = 34'sh0_7FFF_FFFF;
		vmin = 34'sh3_8000_0000;
		if (v > vmax) begin
			return 32'sh7FFF_FFFF;
		end else if (v < vmin) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

FILE: sv/sea_force_pid_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sea_force_pid_controller_unit - series-elastic actuator force PID
// Spring torque estimate, error, clamped integrator and saturated PID output,
// all Q16.16, run by a microcoded sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_stall  | rotor_angle, spring_angle,
//          |                      | torque_setpoint, reference_force
// result   | out_valid / out_stall| drive_torque, measured_torque, saturated
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// - A new input transfer is taken only once the program has finished the last:
//   a 13-step program after the wait step, paced by the single 32x32 multiplier
//   that serves all eight products in turn.
// - The result register decouples the sides: a result may sit stalled while
//   the program finishes the next item, which then waits only in its last step.
// - arst_n clears sequencer, gains, limits, integrator and previous error.
// - cfg_ready is always high; writes to indexes beyond the list are dropped.
//
module sea_force_pid_controller_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// input transfer
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [31:0]           rotor_angle,
	input  logic signed [31:0]           spring_angle,
	input  logic signed [31:0]           torque_setpoint,
	input  logic signed [31:0]           reference_force,
	// result transfer
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [31:0]           drive_torque,
	output logic signed [31:0]           measured_torque,
	output logic                         saturated,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sfpid_pkg::IDX_W-1:0]  cfg_index,
	input  logic [31:0]                  cfg_data
);
	import sfpid_pkg::*;

	// sequencer
	logic [PC_W-1:0] pc_q;
	ucode_t          uc;
	logic            in_xfer;
	logic            out_free;
	logic            jump;

	// configuration registers
	logic signed [31:0] ff_gain_q, kp_gain_q, ki_gain_q, kd_gain_q;
	logic [30:0]        int_lim_q, trq_lim_q;

	// controller state
	logic signed [31:0] integ_q;
	logic signed [31:0] prev_q;

	// datapath
	logic signed [31:0] d_q, setp_q, ref_q;
	logic signed [31:0] lin_q, meas_q, err_q, derr_q;
	logic [46:0]        sq_q;
	logic [63:0]        qacc_q;
	logic signed [49:0] sum_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b;

	// result register
	logic               out_valid_q;
	logic signed [31:0] drive_q, meas_out_q;
	logic               sat_q;

	// combinational helpers
	logic signed [32:0] ang_diff;
	logic signed [31:0] d_sat;
	logic signed [33:0] meas_full;
	logic signed [33:0] integ_sum;
	logic signed [31:0] integ_sat;
	logic signed [33:0] ilim;
	logic signed [31:0] integ_new;
	logic signed [49:0] prod_term;
	logic signed [49:0] tlim;
	logic signed [49:0] drive_full;
	logic               drive_clip;

	assign uc       = ucode_rom(pc_q);
	assign in_stall = (pc_q != PC_WAIT);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (uc.cond)
			C_ALWAYS:   jump = 1'b1;
			C_IN_XFER:  jump = in_xfer;
			C_OUT_FREE: jump = out_free;
			default:    jump = 1'b1;
		endcase
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (uc.a)
			A_D:     mul_a = d_q;
			A_SQH:   mul_a = $signed({1'b0, sq_q[46:16]});
			A_SQL:   mul_a = $signed({16'b0, sq_q[15:0]});
			A_FF:    mul_a = ff_gain_q;
			A_KP:    mul_a = kp_gain_q;
			A_KI:    mul_a = ki_gain_q;
			A_KD:    mul_a = kd_gain_q;
			default: mul_a = d_q;
		endcase
		case (uc.b)
			B_K1:    mul_b = SPRING_K1;
			B_D:     mul_b = d_q;
			B_K2:    mul_b = SPRING_K2;
			B_REF:   mul_b = ref_q;
			B_ERR:   mul_b = err_q;
			B_INT:   mul_b = integ_q;
			B_DERR:  mul_b = derr_q;
			default: mul_b = d_q;
		endcase
	end

	// deflection saturated at capture
	assign ang_diff = {rotor_angle[31], rotor_angle} - {spring_angle[31], spring_angle};
	assign d_sat    = sat32({ang_diff[32], ang_diff});

	// spring torque: linear term less quadratic term (upper 32 bits of qacc)
	assign meas_full = {{2{lin_q[31]}}, lin_q} - $signed({2'b00, qacc_q[63:32]});

	// integrator with anti-windup clamp
	assign integ_sum = {{2{integ_q[31]}}, integ_q} + {{2{err_q[31]}}, err_q};
	assign integ_sat = sat32(integ_sum);
	assign ilim      = $signed({3'b000, int_lim_q});
	always_comb begin
		if ($signed({{2{integ_sat[31]}}, integ_sat}) > ilim) begin
			integ_new = ilim[31:0];
		end else if ($signed({{2{integ_sat[31]}}, integ_sat}) < -ilim) begin
			integ_new = -ilim[31:0];
		end else begin
			integ_new = integ_sat;
		end
	end

	// gain product, floor-shifted by 16
	assign prod_term = {{2{prod_q[63]}}, prod_q[63:16]};

	// output clamp
	assign tlim = $signed({19'b0, trq_lim_q});
	always_comb begin
		if (sum_q > tlim) begin
			drive_full = tlim;
			drive_clip = 1'b1;
		end else if (sum_q < -tlim) begin
			drive_full = -tlim;
			drive_clip = 1'b1;
		end else begin
			drive_full = sum_q;
			drive_clip = 1'b0;
		end
	end

	// control, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_WAIT;
			out_valid_q <= 1'b0;
			ff_gain_q   <= '0;
			kp_gain_q   <= '0;
			ki_gain_q   <= '0;
			kd_gain_q   <= '0;
			int_lim_q   <= '0;
			trq_lim_q   <= '0;
			integ_q     <= '0;
			prev_q      <= '0;
		end else begin
			if (jump) begin
				pc_q <= uc.target;
			end
			if (uc.op == OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (uc.op == OP_INT) begin
				integ_q <= integ_new;
				prev_q  <= err_q;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FF_GAIN: ff_gain_q <= cfg_data;
					REG_KP_GAIN: kp_gain_q <= cfg_data;
					REG_KI_GAIN: ki_gain_q <= cfg_data;
					REG_KD_GAIN: kd_gain_q <= cfg_data;
					REG_INT_LIM: int_lim_q <= cfg_data[30:0];
					REG_TRQ_LIM: trq_lim_q <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_xfer) begin
			d_q    <= d_sat;
			setp_q <= torque_setpoint;
			ref_q  <= reference_force;
		end
		case (uc.op)
			OP_LIN:    lin_q  <= prod_q[63:32];
			OP_SQ:     sq_q   <= prod_q[62:16];
			OP_QH:     qacc_q <= $unsigned(prod_q);
			OP_QL:     qacc_q <= {qacc_q[47:0], 16'b0} + $unsigned(prod_q);
			OP_MEAS:   meas_q <= sat32(meas_full);
			OP_ERR:    err_q  <= sat32({{2{setp_q[31]}}, setp_q} - {{2{meas_q[31]}}, meas_q});
			OP_INT: begin
				derr_q <= sat32({{2{err_q[31]}}, err_q} - {{2{prev_q[31]}}, prev_q});
				sum_q  <= prod_term;
			end
			OP_SUMADD: sum_q  <= sum_q + prod_term;
			OP_OUT: begin
				if (out_free) begin
					drive_q    <= drive_full[31:0];
					sat_q      <= drive_clip;
					meas_out_q <= meas_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign drive_torque    = drive_q;
	assign measured_torque = meas_out_q;
	assign saturated       = sat_q;
	assign cfg_ready       = 1'b1;

	// a clamped result sits exactly on one of the limits
	a_sat_on_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(drive_torque == $signed({1'b0, trq_lim_q}) ||
			 drive_torque == -$signed({1'b0, trq_lim_q})))
		else $error("saturated result not on torque limit");

	// an input transfer starts the program
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> pc_q == 4'd1)
		else $error("program did not start after input transfer");

	// a new result only appears from the output step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pc_q == PC_OUT))
		else $error("result loaded outside output step");

	// the step counter stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_OUT)
		else $error("step counter out of program range");

endmodule

FILE: verif/pid_torque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_torque_checker - torque prediction and in-order result check
// Watches the register, input and result channels of the force PID unit,
// predicts each tick's outputs from its own copy of the controller state and
// compares every returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_torque_checker
	import sfpid_pkg::*;
(
	input  logic             clk,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [31:0]      rotor_angle,
	input  logic [31:0]      spring_angle,
	input  logic [31:0]      torque_setpoint,
	input  logic [31:0]      reference_force,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [31:0]      drive_torque,
	input  logic [31:0]      measured_torque,
	input  logic             saturated,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data,
	output int               failures,
	output int               pending,
	output int               ticks_seen,
	output int               clamps_seen
);

	localparam int     REPORT_LIMIT = 10;
	// spring coefficients, value times 2^32
	localparam longint SPRING_LIN   = 64'sd22419729;
	localparam longint SPRING_QUAD  = 64'sd117682;
	localparam longint WORD_MAX     = 64'sh0000_0000_7FFF_FFFF;
	localparam longint WORD_MIN     = -64'sh0000_0000_8000_0000;

	typedef struct packed {
		logic [31:0] drive;
		logic [31:0] measured;
		logic        clamped;
	} torque_result_t;

	torque_result_t    expected_torques[$];

	logic signed [31:0] ff_gain = '0;
	logic signed [31:0] kp_gain = '0;
	logic signed [31:0] ki_gain = '0;
	logic signed [31:0] kd_gain = '0;
	longint            integral_limit = 0;
	longint            torque_limit   = 0;
	longint            integral_acc   = 0;
	longint            last_error     = 0;

	int fail_count   = 0;
	int result_count = 0;
	int tick_count   = 0;
	int clamp_count  = 0;

	function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint clamp_word(input longint v);
		return clamp_range(v, WORD_MIN, WORD_MAX);
	endfunction

	function automatic void apply_register(input logic [IDX_W-1:0] idx, input logic [31:0] value);
		case (reg_idx_t'(idx))
			REG_FF_GAIN: ff_gain = value;
			REG_KP_GAIN: kp_gain = value;
			REG_KI_GAIN: ki_gain = value;
			REG_KD_GAIN: kd_gain = value;
			REG_INT_LIM: integral_limit = longint'({33'd0, value[30:0]});
			REG_TRQ_LIM: torque_limit = longint'({33'd0, value[30:0]});
			default: ; // spare indexes are dropped
		endcase
	endfunction

	// one control tick: spring estimate, error, integrator, PID sum, clamp
	function automatic torque_result_t predict_tick(input logic signed [31:0] motor,
			input logic signed [31:0] spring, input logic signed [31:0] setpoint,
			input logic signed [31:0] reference);
		longint         deflect;
		longint         lin_term;
		longint         quad_term;
		longint         measured;
		longint         err;
		longint         derr;
		longint         sum;
		longint         drive;
		logic [63:0]    square;
		torque_result_t r;
		deflect   = clamp_word(longint'(motor) - longint'(spring));
		lin_term  = (deflect * SPRING_LIN) >>> 32;
		square    = deflect * deflect;
		square    = (square >> 16) * SPRING_QUAD;
		quad_term = longint'(square >> 32);
		measured  = clamp_word(lin_term - quad_term);

		err          = clamp_word(longint'(setpoint) - measured);
		integral_acc = clamp_range(clamp_word(integral_acc + err), -integral_limit,
			integral_limit);
		derr         = clamp_word(err - last_error);
		last_error   = err;

		sum = ((longint'(ff_gain) * longint'(reference)) >>> 16)
			+ ((longint'(kp_gain) * err) >>> 16)
			+ ((longint'(ki_gain) * integral_acc) >>> 16)
			+ ((longint'(kd_gain) * derr) >>> 16);
		drive = clamp_range(sum, -torque_limit, torque_limit);

		r.drive    = drive[31:0];
		r.measured = measured[31:0];
		r.clamped  = (drive != sum);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		torque_result_t got;
		torque_result_t want;
		if (out_valid && !out_stall) begin
			got = '{drive_torque, measured_torque, saturated};
			result_count++;
			if (got.clamped)
				clamp_count++;
			if (expected_torques.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("result %0d arrived with no tick outstanding: drive %h measured %h sat %b",
						result_count, got.drive, got.measured, got.clamped);
			end else begin
				want = expected_torques.pop_front();
				if (got != want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("result %0d: drive exp %h got %h, measured exp %h got %h, sat exp %b got %b",
							result_count, want.drive, got.drive, want.measured, got.measured,
							want.clamped, got.clamped);
				end
			end
		end
		if (cfg_valid && cfg_ready)
			apply_register(cfg_index, cfg_data);
		if (in_valid && !in_stall) begin
			expected_torques.push_back(predict_tick(rotor_angle, spring_angle,
				torque_setpoint, reference_force));
			tick_count++;
		end
		failures    <= fail_count;
		pending     <= expected_torques.size();
		ticks_seen  <= tick_count;
		clamps_seen <= clamp_count;
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the SEA force PID controller
// Drives directed corner ticks and randomised bursts through the unit under a
// series of gain and limit settings, stalls the result side on its own
// pattern, and reports the failure count gathered by the torque checker.
// ----------------------------------------------------------------------------
module testbench;
	import sfpid_pkg::*;

	// no transfer on any channel for this long means the unit has hung
	localparam int WATCHDOG_LIMIT  = 5000;
	// quiet cycles after the last result, longer than one full pass of the program
	localparam int SETTLE_CYCLES   = 30;
	localparam int RANDOM_PHASES   = 14;
	localparam int TICKS_PER_PHASE = 100;

	// Q16.16 values and spans used to shape the random fields
	localparam logic [31:0] Q_ONE        = 32'h0001_0000;
	localparam logic [31:0] WORD_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
	localparam int unsigned ANGLE_SPAN   = 360 * 65536;
	localparam int unsigned DEFLECT_SPAN = 30 * 65536;
	localparam int unsigned TORQUE_SPAN  = 16 * 65536;
	localparam int unsigned GAIN_SPAN    = 8 * 65536;
	localparam int unsigned LIMIT_SPAN   = 64 * 65536;

	// indexes past the register list; the unit must drop these writes
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {
		STALL_NONE,   // result side always ready
		STALL_LIGHT,  // odd stall cycle
		STALL_HEAVY,  // mostly stalled
		STALL_RUNS    // long alternating runs
	} stall_mode_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [31:0]      rotor_angle;
	logic [31:0]      spring_angle;
	logic [31:0]      torque_setpoint;
	logic [31:0]      reference_force;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [31:0]      drive_torque;
	logic [31:0]      measured_torque;
	logic             saturated;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [31:0]      cfg_data;

	int failures;
	int pending;
	int ticks_seen;
	int clamps_seen;

	int          idle_cycles    = 0;
	int          settings_count = 0;
	stall_mode_t stall_mode     = STALL_NONE;
	int          mode_left      = 0;
	int          run_left       = 0;

	sea_force_pid_controller_unit dut (.*);

	pid_torque_checker torque_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: pick a stall style for a stretch of cycles, then another.
	// Includes stretches with no stall at all so back-to-back transfers occur.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(40, 300);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 40);
					out_stall <= ~out_stall;
				end
				run_left--;
			end
		endcase
	end

	// Watchdog: any transfer, or reset, restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Mostly small signed values, now and then a rail or a full-width word.
	function automatic logic [31:0] pick_value(input int unsigned span);
		case ($urandom_range(0, 15))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2, 3, 4: return $urandom();
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	// Limit registers are 31 bits; a full random word also exercises bit 31,
	// which the unit must ignore.
	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return WORD_MAX;
			2:       return $urandom();
			default: return $urandom_range(0, LIMIT_SPAN);
		endcase
	endfunction

	// Present one tick and hold it until the unit takes it. Valid is left high
	// so a following tick can go back to back.
	task automatic send_tick(input logic [31:0] motor, input logic [31:0] spring,
			input logic [31:0] setpoint, input logic [31:0] reference);
		in_valid        <= 1'b1;
		rotor_angle     <= motor;
		spring_angle    <= spring;
		torque_setpoint <= setpoint;
		reference_force <= reference;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// New gains and limits, only once every outstanding result is back.
	// Spare indexes are hit last so an aliased decode would corrupt a register.
	task automatic apply_gains(input logic [31:0] ff, input logic [31:0] kp,
			input logic [31:0] ki, input logic [31:0] kd, input logic [31:0] int_lim,
			input logic [31:0] trq_lim);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		write_register(REG_FF_GAIN, ff);
		write_register(REG_KP_GAIN, kp);
		write_register(REG_KI_GAIN, ki);
		write_register(REG_KD_GAIN, kd);
		write_register(REG_INT_LIM, int_lim);
		write_register(REG_TRQ_LIM, trq_lim);
		write_register(REG_SPARE_LO, $urandom());
		write_register(REG_SPARE_HI, $urandom());
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// Bursts of random length with random gaps; about one gap in four is
	// skipped so bursts also run straight into each other.
	task automatic run_random_ticks(input int count);
		int          left;
		int          burst;
		int          gap;
		logic [31:0] motor;
		logic [31:0] spring;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				motor = pick_value(ANGLE_SPAN);
				// spring side mostly tracks the motor within a plausible deflection
				spring = ($urandom_range(0, 3) == 0) ? pick_value(ANGLE_SPAN)
					: motor - pick_value(DEFLECT_SPAN);
				send_tick(motor, spring, pick_value(TORQUE_SPAN), pick_value(TORQUE_SPAN));
				burst--;
				left--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
	endtask

	initial begin : stimulus
		int phase;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		rotor_angle     = '0;
		spring_angle    = '0;
		torque_setpoint = '0;
		reference_force = '0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		// Out of reset every gain and limit is zero: the drive torque must be zero
		// whatever the angles, rails included.
		send_tick('0, '0, '0, '0);
		send_tick(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
		send_tick(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);

		// Zero limits with unity gains: integrator pinned at zero, output held
		// at zero and flagged whenever the raw sum is nonzero.
		apply_gains(Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0, '0);
		send_tick('0, '0, 32'h0002_0000, 32'h0003_0000);
		send_tick('0, '0, '0, '0);

		// Feedforward alone, landing exactly on the limit (no flag) and one
		// LSB beyond it (flag), on both sides.
		apply_gains(Q_ONE, '0, '0, '0, WORD_MAX, 32'h00A0_0000);
		send_tick('0, '0, '0, 32'h00A0_0000);
		send_tick('0, '0, '0, 32'h00A0_0001);
		send_tick('0, '0, '0, 32'hFF60_0000);
		send_tick('0, '0, '0, 32'hFF5F_FFFF);

		// Proportional only: tiny deflections either side of zero test the
		// floor of the linear term; large ones bring in the quadratic term.
		apply_gains('0, Q_ONE, '0, '0, WORD_MAX, WORD_MAX);
		send_tick('0, 32'h0000_0001, '0, '0);
		send_tick(32'h0000_0001, '0, '0, '0);
		send_tick(32'h0500_0000, 32'hFB00_0000, '0, '0);
		send_tick(32'hFB00_0000, 32'h0500_0000, '0, '0);

		// Extreme gains and full-width limits: drive the integrator into the
		// positive rail, then swing to the negative clamp, saturating the
		// error difference on the way.
		apply_gains(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
		repeat (3)
			send_tick('0, '0, WORD_MAX, WORD_MAX);
		repeat (3)
			send_tick('0, '0, WORD_MIN, WORD_MIN);
		send_tick(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);

		// Random settings, each followed by a stretch of random ticks.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			apply_gains(pick_value(GAIN_SPAN), pick_value(GAIN_SPAN), pick_value(GAIN_SPAN),
				pick_value(GAIN_SPAN), pick_limit(), pick_limit());
			run_random_ticks(TICKS_PER_PHASE);
		end

		// Drain, then give the unit time to produce anything unexpected.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("%0d control ticks checked over %0d register settings, %0d outputs clamped",
			ticks_seen, settings_count, clamps_seen);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatching or unexpected results", failures);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
